// File: rtl/ctrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctrp_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAIN_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUB_ADDRESS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUB_ENABLE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TICKS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TICKS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TICKS   = 3'd5;

    localparam logic [15:0] PRESS_TICKS_RESET  = 16'd20;
    localparam logic [15:0] PERIOD_TICKS_RESET = 16'd100;
    localparam logic [15:0] IDLE_TICKS_RESET   = 16'd15;

    localparam logic [15:0] RING_LENGTH = 16'd16;
    localparam logic [7:0]  RING_HEAD   = 8'h80;
    localparam logic [7:0]  RING_KIND_A = 8'h60;
    localparam logic [7:0]  RING_KIND_B = 8'hE0;

    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_DATAGRAM = 1'b1;

    typedef struct packed {
        logic [31:0] main_address;
        logic [31:0] sub_address;
        logic        sub_enable;
    } t_match_cfg;

    typedef struct packed {
        logic [15:0] press_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] idle_ticks;
    } t_timing;

    typedef struct packed {
        logic kind;
        logic ring;
        logic main_hit;
        logic sub_hit;
    } t_item;

endpackage

`default_nettype wire

// File: rtl/ctrp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ctrp_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] datagram_length;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [31:0] source_address;

    modport source (output valid, kind, datagram_length, first_byte, second_byte,
                    source_address, input ready);
    modport sink (input valid, kind, datagram_length, first_byte, second_byte,
                  source_address, output ready);
endinterface

interface ctrp_out_if;
    logic valid;
    logic ready;
    logic main_relay;
    logic sub_relay;
    logic main_calling;
    logic sub_calling;
    logic ring_seen;

    modport source (output valid, main_relay, sub_relay, main_calling, sub_calling,
                    ring_seen, input ready);
    modport sink (input valid, main_relay, sub_relay, main_calling, sub_calling,
                  ring_seen, output ready);
endinterface

interface ctrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/ctrp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ctrp_front
    import ctrp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    ctrp_in_if.sink    i_item,
    input  t_match_cfg i_match_cfg,
    output logic       o_valid,
    output t_item      o_item,
    input  wire        i_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign i_item.ready = !r_valid || i_ready;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        n_item.kind = i_item.kind;
        n_item.ring = (i_item.kind == KIND_DATAGRAM) &&
                      (i_item.datagram_length == RING_LENGTH) &&
                      (i_item.first_byte == RING_HEAD) &&
                      ((i_item.second_byte == RING_KIND_A) ||
                       (i_item.second_byte == RING_KIND_B));
        n_item.main_hit = (i_item.source_address == i_match_cfg.main_address);
        n_item.sub_hit  = i_match_cfg.sub_enable &&
                          (i_item.source_address == i_match_cfg.sub_address);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: rtl/ctrp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ctrp_queue
    import ctrp_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  wire   i_ready
);

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ctrp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ctrp_back
    import ctrp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  t_item      i_item,
    output logic       o_ready,
    input  t_timing    i_timing,
    ctrp_out_if.source o_result
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_PRESS = 4'b0010,
        PH_GAP   = 4'b0100,
        PH_WIND  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        calling;
        t_phase      phase;
        logic [15:0] counter;
        logic        rearm;
    } t_chan;

    typedef struct packed {
        logic main_relay;
        logic sub_relay;
        logic main_calling;
        logic sub_calling;
        logic ring_seen;
    } t_result;

    t_chan       r_chan [2];
    t_chan       n_chan [2];
    logic [15:0] r_idle;
    logic [15:0] n_idle;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        pop;
    logic [15:0] idle_inc;

    function automatic t_chan f_start(input t_chan c);
        t_chan s;
        s         = c;
        s.calling = 1'b1;
        s.phase   = PH_PRESS;
        s.counter = 16'd0;
        s.rearm   = 1'b0;
        return s;
    endfunction

    function automatic t_chan f_advance(input t_chan c, input t_timing t);
        t_chan       s;
        logic [15:0] len;
        logic [15:0] cnt;
        s   = c;
        len = (c.phase == PH_PRESS) ? t.press_ticks : t.gap_ticks;
        cnt = (c.counter == 16'hFFFF) ? c.counter : c.counter + 16'd1;
        case (c.phase)
            PH_PRESS, PH_GAP: begin
                if (cnt >= len) begin
                    s.phase   = (c.phase == PH_PRESS) ? PH_GAP : PH_PRESS;
                    s.counter = 16'd0;
                end else begin
                    s.counter = cnt;
                end
            end
            PH_WIND: begin
                if (c.counter <= 16'd1) begin
                    if (c.rearm) begin
                        s = f_start(c);
                    end else begin
                        s.phase   = PH_IDLE;
                        s.counter = 16'd0;
                    end
                end else begin
                    s.counter = c.counter - 16'd1;
                end
            end
            default: s = c;
        endcase
        return s;
    endfunction

    function automatic t_chan f_end_call(input t_chan c, input t_timing t);
        t_chan       s;
        logic [15:0] len;
        s   = c;
        len = (c.phase == PH_PRESS) ? t.press_ticks : t.gap_ticks;
        if (c.calling) begin
            s.calling = 1'b0;
            if ((c.phase == PH_PRESS) || (c.phase == PH_GAP)) begin
                s.counter = (len > c.counter) ? len - c.counter : 16'd0;
                s.phase   = PH_WIND;
                s.rearm   = 1'b0;
            end else begin
                s.phase   = PH_IDLE;
                s.counter = 16'd0;
            end
        end
        return s;
    endfunction

    function automatic t_chan f_match(input t_chan c);
        t_chan s;
        s = c;
        if (c.phase == PH_WIND) begin
            s.rearm = 1'b1;
        end else begin
            s = f_start(c);
        end
        return s;
    endfunction

    assign o_ready  = !r_out_valid || o_result.ready;
    assign pop      = i_valid && o_ready;
    assign idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;

    always_comb begin
        n_chan[0] = r_chan[0];
        n_chan[1] = r_chan[1];
        n_idle    = r_idle;
        if (i_item.kind == KIND_DATAGRAM) begin
            n_idle = 16'd0;
            if (i_item.ring) begin
                if (i_item.main_hit && !r_chan[0].calling) begin
                    n_chan[0] = f_match(r_chan[0]);
                end else if (i_item.sub_hit && !r_chan[1].calling) begin
                    n_chan[1] = f_match(r_chan[1]);
                end
            end
        end else begin
            n_chan[0] = f_advance(r_chan[0], i_timing);
            n_chan[1] = f_advance(r_chan[1], i_timing);
            if (idle_inc >= i_timing.idle_ticks) begin
                n_idle    = 16'd0;
                n_chan[0] = f_end_call(n_chan[0], i_timing);
                n_chan[1] = f_end_call(n_chan[1], i_timing);
            end else begin
                n_idle = idle_inc;
            end
        end
        n_out.main_relay   = (n_chan[0].phase == PH_PRESS);
        n_out.sub_relay    = (n_chan[1].phase == PH_PRESS);
        n_out.main_calling = n_chan[0].calling;
        n_out.sub_calling  = n_chan[1].calling;
        n_out.ring_seen    = (i_item.kind == KIND_DATAGRAM) && i_item.ring;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_chan[i].calling <= 1'b0;
                r_chan[i].phase   <= PH_IDLE;
                r_chan[i].counter <= 16'd0;
                r_chan[i].rearm   <= 1'b0;
            end
            r_idle      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_chan[0] <= n_chan[0];
                r_chan[1] <= n_chan[1];
                r_idle    <= n_idle;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.main_relay   = r_out.main_relay;
    assign o_result.sub_relay    = r_out.sub_relay;
    assign o_result.main_calling = r_out.main_calling;
    assign o_result.sub_calling  = r_out.sub_calling;
    assign o_result.ring_seen    = r_out.ring_seen;

endmodule

`default_nettype wire

// File: rtl/call_triggered_relay_pulser.sv
// Path: an accepted request passes the front register, a queue entry and the back output register,
// the first loaded at the accepting edge.
// Throughput: one request per cycle, sustained while the result side takes one per cycle.
// Reset: synchronous, active low; clears both channels, the idle counter and the queue,
// and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module call_triggered_relay_pulser
    import ctrp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    ctrp_in_if.sink    i_item,
    ctrp_cfg_if.sink   i_cfg,
    ctrp_out_if.source o_result
);

    logic [31:0] r_main_address;
    logic [31:0] r_sub_address;
    logic        r_sub_enable;
    logic [15:0] r_press_ticks;
    logic [15:0] r_period_ticks;
    logic [15:0] r_idle_ticks;

    t_match_cfg match_cfg;
    t_timing    timing;
    logic       f_valid;
    t_item      f_item;
    logic       q_ready;
    logic       q_valid;
    t_item      q_item;
    logic       b_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_address <= 32'd0;
            r_sub_address  <= 32'd0;
            r_sub_enable   <= 1'b0;
            r_press_ticks  <= PRESS_TICKS_RESET;
            r_period_ticks <= PERIOD_TICKS_RESET;
            r_idle_ticks   <= IDLE_TICKS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MAIN_ADDRESS: r_main_address <= i_cfg.data;
                REG_SUB_ADDRESS:  r_sub_address  <= i_cfg.data;
                REG_SUB_ENABLE:   r_sub_enable   <= i_cfg.data[0];
                REG_PRESS_TICKS:  r_press_ticks  <= i_cfg.data[15:0];
                REG_PERIOD_TICKS: r_period_ticks <= i_cfg.data[15:0];
                REG_IDLE_TICKS:   r_idle_ticks   <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        match_cfg.main_address = r_main_address;
        match_cfg.sub_address  = r_sub_address;
        match_cfg.sub_enable   = r_sub_enable;
        timing.press_ticks     = r_press_ticks;
        timing.gap_ticks       = (r_period_ticks > r_press_ticks) ?
                                 r_period_ticks - r_press_ticks : 16'd0;
        timing.idle_ticks      = r_idle_ticks;
    end

    ctrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_match_cfg (match_cfg),
        .o_valid     (f_valid),
        .o_item      (f_item),
        .i_ready     (q_ready)
    );

    ctrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_ready (b_ready)
    );

    ctrp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_ready  (b_ready),
        .i_timing (timing),
        .o_result (o_result)
    );

    a_main_press_calls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.main_relay) |-> o_result.main_calling)
        else $error("main relay pressed without a call");

    a_sub_press_calls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.sub_relay) |-> o_result.sub_calling)
        else $error("sub relay pressed without a call");

    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && !q_ready) |=> f_valid)
        else $error("front stage dropped a request while the queue was full");

endmodule

`default_nettype wire
